@@ design/b32k_pkg.sv @@
// Shared types, constants and helper functions for the bech32 secret key decoder.
// No dependencies; the decoder top, the character map and the core import this package.

package b32k_pkg;

  // string layout
  localparam logic [6:0] TOTAL_LEN  = 7'd63;
  localparam logic [6:0] PREFIX_LEN = 7'd5;
  localparam logic [6:0] DATA_END   = 7'd57;
  localparam logic [6:0] POS_MAX    = 7'd127;
  localparam logic [5:0] KEY_BYTES  = 6'd32;

  // final status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NONCANON  = 3'd1,
    ST_MALFORMED = 3'd2,
    ST_BADCHAR   = 3'd3,
    ST_CHECKSUM  = 3'd4,
    ST_PADDING   = 3'd5,
    ST_SCALAR    = 3'd6
  } status_t;

  // error flag bit positions (one per nonzero status code)
  localparam int EB_NONCANON  = 0;
  localparam int EB_MALFORMED = 1;
  localparam int EB_BADCHAR   = 2;
  localparam int EB_CHECKSUM  = 3;
  localparam int EB_PADDING   = 4;
  localparam int EB_SCALAR    = 5;

  // running comparison against the group order
  typedef enum logic [1:0] {
    CMP_EQUAL   = 2'd0,
    CMP_LESS    = 2'd1,
    CMP_GREATER = 2'd2
  } cmp_t;

  // output item kinds
  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // bch generators
  localparam logic [29:0] GEN [5] = '{
    30'h3B6A57B2, 30'h26508E6D, 30'h1EA119FA, 30'h3D4233DD, 30'h2A1462B3
  };

  // human readable part
  localparam logic [7:0] HRP [4] = '{8'h6E, 8'h73, 8'h65, 8'h63};

  // secp256k1 group order, most significant byte first
  localparam logic [7:0] ORDER [32] = '{
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFE,
    8'hBA, 8'hAE, 8'hDC, 8'hE6, 8'hAF, 8'h48, 8'hA0, 8'h3B,
    8'hBF, 8'hD2, 8'h5E, 8'h8C, 8'hD0, 8'h36, 8'h41, 8'h41
  };

  // character classification passed from the mapper to the core
  typedef struct packed {
    logic [4:0] value;
    logic       in_alpha;
    logic       is_one;
    logic       is_upper;
    logic       is_space;
  } char_info_t;

  // one result item
  typedef struct packed {
    logic       valid;
    logic       kind;
    logic [7:0] key_byte;
    logic [4:0] byte_index;
    logic [2:0] status;
  } result_t;

  // one polymod step: shift in a 5-bit word, fold the top bits back
  function automatic logic [29:0] poly_step(input logic [29:0] c, input logic [4:0] v);
    logic [4:0]  top;
    logic [29:0] r;
    top = c[29:25];
    r   = {c[24:0], v};
    for (int i = 0; i < 5; i++) begin
      if (top[i]) begin
        r = r ^ GEN[i];
      end
    end
    return r;
  endfunction

  // residue of the expanded prefix, evaluated at elaboration
  function automatic logic [29:0] poly_init();
    logic [29:0] c;
    c = 30'd1;
    for (int i = 0; i < 4; i++) begin
      c = poly_step(c, {2'b00, HRP[i][7:5]});
    end
    c = poly_step(c, 5'd0);
    for (int i = 0; i < 4; i++) begin
      c = poly_step(c, HRP[i][4:0]);
    end
    return c;
  endfunction

  localparam logic [29:0] POLY_INIT = poly_init();

  // expected character at each prefix position
  function automatic logic [7:0] prefix_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = 8'h6E;
      3'd1:    ch = 8'h73;
      3'd2:    ch = 8'h65;
      3'd3:    ch = 8'h63;
      3'd4:    ch = 8'h31;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

@@ design/b32k_in_if.sv @@
// Request channel carrying one character of the encoded string.
// Uses no package.

interface b32k_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_string;

  modport source (output valid, output char_in, output end_of_string, input ready);
  modport sink (input valid, input char_in, input end_of_string, output ready);
endinterface

@@ design/b32k_out_if.sv @@
// Result channel carrying key bytes and the final status.
// Uses no package.

interface b32k_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] key_byte;
  logic [4:0] byte_index;
  logic [2:0] status;

  modport source (output valid, output kind, output key_byte, output byte_index,
                  output status, input ready);
  modport sink (input valid, input kind, input key_byte, input byte_index,
                input status, output ready);
endinterface

@@ design/bech32_secret_key_decoder.sv @@
// Streaming decoder for a bech32 "nsec" secret key string.
// Depends on b32k_pkg, b32k_in_if, b32k_out_if and b32k_core.
//
// Usage:
//   in_chan carries one ASCII character per request, with end_of_string high
//   on the last character. out_chan returns a key byte request (kind 0) for
//   each of the 32 key bytes as it forms, most significant first, and one
//   status request (kind 1) for the last character of each string. A byte
//   that forms on the last character is not sent; only the status is.
//   Timing: a character is registered in the input register on acceptance,
//   then decoded into the output register once that register is free. One
//   character per cycle is sustained while out_chan takes the results; the
//   limit is the single decode stage, whose polymod and repack state carry
//   from one character to the next.
//   Stall: while out_chan is held, the input register still takes one more
//   character; after that in_chan.ready drops until the result is taken.
//   Reset: rst_n low clears both registers and returns the decoder to the
//   start of a string. After every status it starts a new string by itself.

module bech32_secret_key_decoder (
  input  logic        clk,
  input  logic        rst_n,
  b32k_in_if.sink     in_chan,
  b32k_out_if.source  out_chan
);
  import b32k_pkg::*;

  logic       s1_valid_r;
  logic       s1_valid_nxt;
  logic [7:0] s1_char_r;
  logic       s1_eos_r;
  logic       out_valid_r;
  result_t    out_r;
  result_t    res;
  logic       out_free;
  logic       step;
  logic       in_take;

  // handshake control
  assign out_free      = !out_valid_r || out_chan.ready;
  assign step          = s1_valid_r && out_free;
  assign in_chan.ready = !s1_valid_r || out_free;
  assign in_take       = in_chan.valid && in_chan.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (step) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_char_r <= in_chan.char_in;
      s1_eos_r  <= in_chan.end_of_string;
    end
  end

  // decode stage
  b32k_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .ch    (s1_char_r),
    .eos   (s1_eos_r),
    .res   (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= step && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && step && res.valid) begin
      out_r <= res;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.kind       = out_r.kind;
  assign out_chan.key_byte   = out_r.key_byte;
  assign out_chan.byte_index = out_r.byte_index;
  assign out_chan.status     = out_r.status;

endmodule

@@ design/b32k_char_map.sv @@
// Character classifier: bech32 alphabet lookup and character class flags.
// Depends on b32k_pkg.

module b32k_char_map (
  input  logic [7:0]           ch,
  output b32k_pkg::char_info_t info
);
  import b32k_pkg::*;

  logic [4:0] value;
  logic       found;

  // alphabet lookup
  always_comb begin
    found = 1'b1;
    case (ch)
      "q":     value = 5'd0;
      "p":     value = 5'd1;
      "z":     value = 5'd2;
      "r":     value = 5'd3;
      "y":     value = 5'd4;
      "9":     value = 5'd5;
      "x":     value = 5'd6;
      "8":     value = 5'd7;
      "g":     value = 5'd8;
      "f":     value = 5'd9;
      "2":     value = 5'd10;
      "t":     value = 5'd11;
      "v":     value = 5'd12;
      "d":     value = 5'd13;
      "w":     value = 5'd14;
      "0":     value = 5'd15;
      "s":     value = 5'd16;
      "3":     value = 5'd17;
      "j":     value = 5'd18;
      "n":     value = 5'd19;
      "5":     value = 5'd20;
      "4":     value = 5'd21;
      "k":     value = 5'd22;
      "h":     value = 5'd23;
      "c":     value = 5'd24;
      "e":     value = 5'd25;
      "6":     value = 5'd26;
      "m":     value = 5'd27;
      "u":     value = 5'd28;
      "a":     value = 5'd29;
      "7":     value = 5'd30;
      "l":     value = 5'd31;
      default: begin
        value = 5'd0;
        found = 1'b0;
      end
    endcase
  end

  // class flags
  always_comb begin
    info.value    = value;
    info.in_alpha = found;
    info.is_one   = (ch == 8'h31);
    info.is_upper = (ch inside {[8'h41:8'h5A]});
    info.is_space = (ch inside {8'h20, 8'h0A, 8'h0D, 8'h09});
  end

endmodule

@@ design/b32k_core.sv @@
// Per-string decode state: polymod, bit repacker, order compare and error flags.
// Depends on b32k_pkg and b32k_char_map.

module b32k_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          ch,
  input  logic                eos,
  output b32k_pkg::result_t   res
);
  import b32k_pkg::*;

  char_info_t  info;

  logic [6:0]  pos_r;
  logic [29:0] poly_r;
  logic [6:0]  acc_r;
  logic [2:0]  pend_r;
  logic [5:0]  cnt_r;
  cmp_t        cmp_r;
  logic        nz_r;
  logic [5:0]  err_r;

  logic [6:0]  pos_nxt;
  logic [29:0] poly_nxt;
  logic [6:0]  acc_nxt;
  logic [2:0]  pend_nxt;
  logic [5:0]  cnt_nxt;
  cmp_t        cmp_nxt;
  logic        nz_nxt;
  logic [5:0]  err_nxt;

  logic [4:0]  v;
  logic [11:0] acc_w;
  logic [3:0]  pend5;
  logic [2:0]  pend_w;
  logic [11:0] shifted;
  logic [7:0]  byte_val;
  logic        have_byte;
  logic [5:0]  fin_err;
  status_t     status;

  b32k_char_map u_map (
    .ch   (ch),
    .info (info)
  );

  // next state and result for one character
  always_comb begin
    pos_nxt   = pos_r;
    poly_nxt  = poly_r;
    acc_nxt   = acc_r;
    pend_nxt  = pend_r;
    cnt_nxt   = cnt_r;
    cmp_nxt   = cmp_r;
    nz_nxt    = nz_r;
    err_nxt   = err_r;
    have_byte = 1'b0;
    v         = info.in_alpha ? info.value : 5'd0;
    acc_w     = {acc_r, v};
    pend5     = {1'b0, pend_r} + 4'd5;
    pend_w    = pend5[2:0];
    shifted   = acc_w >> pend_w;
    byte_val  = shifted[7:0];

    // case checks
    if (info.is_upper) begin
      err_nxt[EB_NONCANON] = 1'b1;
    end
    if (((pos_r == 7'd0) || eos) && info.is_space) begin
      err_nxt[EB_NONCANON] = 1'b1;
    end

    if (pos_r < PREFIX_LEN) begin
      // prefix compare
      if (ch != prefix_char(pos_r[2:0])) begin
        err_nxt[EB_MALFORMED] = 1'b1;
      end
    end else if (pos_r < TOTAL_LEN) begin
      // data or checksum word
      if (info.is_one) begin
        err_nxt[EB_MALFORMED] = 1'b1;
      end else if (!info.in_alpha) begin
        err_nxt[EB_BADCHAR] = 1'b1;
      end
      poly_nxt = poly_step(poly_r, v);
      if (pos_r < DATA_END) begin
        // repack into bytes
        if (pend5[3] && !cnt_r[5]) begin
          have_byte = 1'b1;
          if (cmp_r == CMP_EQUAL) begin
            if (byte_val < ORDER[cnt_r[4:0]]) begin
              cmp_nxt = CMP_LESS;
            end else if (byte_val > ORDER[cnt_r[4:0]]) begin
              cmp_nxt = CMP_GREATER;
            end
          end
          if (byte_val != 8'd0) begin
            nz_nxt = 1'b1;
          end
          cnt_nxt = cnt_r + 6'd1;
        end
        acc_nxt  = acc_w[6:0] & (7'h7F >> (3'd7 - pend_w));
        pend_nxt = pend_w;
      end
    end else begin
      err_nxt[EB_MALFORMED] = 1'b1;
    end

    if (pos_r != POS_MAX) begin
      pos_nxt = pos_r + 7'd1;
    end

    // end of string checks
    fin_err = err_nxt;
    if (pos_r != (TOTAL_LEN - 7'd1)) begin
      fin_err[EB_MALFORMED] = 1'b1;
    end
    if (poly_nxt != 30'd1) begin
      fin_err[EB_CHECKSUM] = 1'b1;
    end
    if ((acc_nxt[3:0] != 4'd0) || (pend_nxt >= 3'd5)) begin
      fin_err[EB_PADDING] = 1'b1;
    end
    if (!nz_nxt || (cmp_nxt != CMP_LESS)) begin
      fin_err[EB_SCALAR] = 1'b1;
    end

    // lowest code wins
    if (fin_err[EB_NONCANON]) begin
      status = ST_NONCANON;
    end else if (fin_err[EB_MALFORMED]) begin
      status = ST_MALFORMED;
    end else if (fin_err[EB_BADCHAR]) begin
      status = ST_BADCHAR;
    end else if (fin_err[EB_CHECKSUM]) begin
      status = ST_CHECKSUM;
    end else if (fin_err[EB_PADDING]) begin
      status = ST_PADDING;
    end else if (fin_err[EB_SCALAR]) begin
      status = ST_SCALAR;
    end else begin
      status = ST_OK;
    end

    // result item
    res = '0;
    if (eos) begin
      res.valid  = 1'b1;
      res.kind   = KIND_STATUS;
      res.status = status;
    end else if (have_byte) begin
      res.valid      = 1'b1;
      res.kind       = KIND_BYTE;
      res.key_byte   = byte_val;
      res.byte_index = cnt_r[4:0];
    end
  end

  // decode state, back to its start value after each final status
  always_ff @(posedge clk) begin
    if (!rst_n || (step && eos)) begin
      pos_r  <= 7'd0;
      poly_r <= POLY_INIT;
      acc_r  <= 7'd0;
      pend_r <= 3'd0;
      cnt_r  <= 6'd0;
      cmp_r  <= CMP_EQUAL;
      nz_r   <= 1'b0;
      err_r  <= 6'd0;
    end else if (step) begin
      pos_r  <= pos_nxt;
      poly_r <= poly_nxt;
      acc_r  <= acc_nxt;
      pend_r <= pend_nxt;
      cnt_r  <= cnt_nxt;
      cmp_r  <= cmp_nxt;
      nz_r   <= nz_nxt;
      err_r  <= err_nxt;
    end
  end

endmodule

@@ verif/b32k_tb_pkg.sv @@
`timescale 1ns / 100ps
// Constants and helpers shared by the nsec decoder checker and its stimulus:
// the bech32 charset, the bch polymod step and the secp256k1 group order. No dependencies.

package b32k_tb_pkg;

  // string layout
  localparam int STR_LEN   = 63;
  localparam int HEAD_LEN  = 5;
  localparam int WORDS_END = 57;
  localparam int KEY_LEN   = 32;
  localparam int POS_CEIL  = 127;

  localparam logic [255:0] CHARSET    = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";
  localparam logic [39:0]  KEY_PREFIX = "nsec1";

  localparam logic [29:0] BCH_GEN [5] = '{
    30'h3B6A57B2, 30'h26508E6D, 30'h1EA119FA, 30'h3D4233DD, 30'h2A1462B3
  };

  // secp256k1 order, most significant byte first
  localparam logic [7:0] GROUP_ORDER [32] = '{
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFE,
    8'hBA, 8'hAE, 8'hDC, 8'hE6, 8'hAF, 8'h48, 8'hA0, 8'h3B,
    8'hBF, 8'hD2, 8'h5E, 8'h8C, 8'hD0, 8'h36, 8'h41, 8'h41
  };

  // 5-bit word to its character
  function automatic logic [7:0] charset_char(input logic [4:0] w);
    return CHARSET[8 * (31 - int'(w)) +: 8];
  endfunction

  // character to its 5-bit word; word 0 when not in the charset
  function automatic logic charset_word(input logic [7:0] ch, output logic [4:0] w);
    logic hit;
    hit = 1'b0;
    w   = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (!hit && CHARSET[8 * (31 - i) +: 8] == ch) begin
        hit = 1'b1;
        w   = 5'(i);
      end
    end
    return hit;
  endfunction

  function automatic logic [7:0] prefix_byte(input int i);
    return KEY_PREFIX[8 * (4 - i) +: 8];
  endfunction

  // shift one word into the checksum, folding back the top five bits
  function automatic logic [29:0] bch_shift(input logic [29:0] c, input logic [4:0] w);
    logic [29:0] r;
    r = {c[24:0], w};
    for (int g = 0; g < 5; g++) begin
      if (c[25 + g]) begin
        r ^= BCH_GEN[g];
      end
    end
    return r;
  endfunction

  // residue after the expanded "nsec" part
  function automatic logic [29:0] hrp_residue();
    logic [29:0] c;
    c = 30'd1;
    for (int i = 0; i < 4; i++) begin
      c = bch_shift(c, 5'(prefix_byte(i) >> 5));
    end
    c = bch_shift(c, 5'd0);
    for (int i = 0; i < 4; i++) begin
      c = bch_shift(c, 5'(prefix_byte(i)));
    end
    return c;
  endfunction

endpackage

@@ verif/nsec_decode_checker.sv @@
`timescale 1ns / 100ps
// Watches both channels of the nsec decoder, predicts key bytes and the final status
// of each string, and counts mismatches. Depends on b32k_pkg, b32k_tb_pkg and the interfaces.

module nsec_decode_checker (
  input  logic        clk,
  input  logic        rst_n,
  b32k_in_if          in_mon,
  b32k_out_if         out_mon,
  output int unsigned failures,
  output int unsigned outstanding
);
  import b32k_pkg::*;
  import b32k_tb_pkg::*;

  typedef enum logic [1:0] {ORD_EQUAL, ORD_BELOW, ORD_ABOVE} order_cmp_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] key_byte;
    logic [4:0] byte_index;
    status_t    status;
  } key_result_t;

  // decoder state for the string in progress
  logic [6:0]  char_pos;
  logic [29:0] residue;
  logic [7:0]  bit_acc;
  logic [3:0]  bit_fill;
  logic [5:0]  bytes_out;
  order_cmp_t  order_cmp;
  logic        key_nonzero;
  logic [6:1]  err_flags;

  key_result_t key_results_due [$];
  int unsigned fail_total = 0;

  assign failures = fail_total;

  task automatic clear_string();
    char_pos    = '0;
    residue     = hrp_residue();
    bit_acc     = '0;
    bit_fill    = '0;
    bytes_out   = '0;
    order_cmp   = ORD_EQUAL;
    key_nonzero = 1'b0;
    err_flags   = '0;
  endtask

  // advance the decoder by one character and queue what it produces
  task automatic decode_char(input logic [7:0] ch, input logic last);
    logic [6:0]  pos;
    logic [4:0]  w;
    logic [11:0] acc;
    logic [3:0]  nbits;
    logic [7:0]  bval;
    logic [4:0]  bidx;
    logic        got_byte;
    status_t     st;
    key_result_t due;
    pos      = char_pos;
    got_byte = 1'b0;
    bval     = '0;
    bidx     = '0;
    w        = '0;

    // case and surrounding whitespace
    if (ch >= "A" && ch <= "Z") begin
      err_flags[ST_NONCANON] = 1'b1;
    end
    if ((pos == 0 || last) && (ch == " " || ch == 8'h09 || ch == 8'h0A || ch == 8'h0D)) begin
      err_flags[ST_NONCANON] = 1'b1;
    end

    if (pos < HEAD_LEN) begin
      if (ch != prefix_byte(pos)) begin
        err_flags[ST_MALFORMED] = 1'b1;
      end
    end else if (pos < STR_LEN) begin
      if (ch == "1") begin
        err_flags[ST_MALFORMED] = 1'b1;
      end else if (!charset_word(ch, w)) begin
        err_flags[ST_BADCHAR] = 1'b1;
      end
      residue = bch_shift(residue, w);

      // repack data words into key bytes
      if (pos < WORDS_END) begin
        acc   = {bit_acc[6:0], w};
        nbits = bit_fill + 4'd5;
        if (nbits >= 4'd8) begin
          nbits = nbits - 4'd8;
          bval  = 8'(acc >> nbits);
          if (bytes_out < KEY_LEN) begin
            if (order_cmp == ORD_EQUAL) begin
              if (bval < GROUP_ORDER[bytes_out[4:0]]) begin
                order_cmp = ORD_BELOW;
              end else if (bval > GROUP_ORDER[bytes_out[4:0]]) begin
                order_cmp = ORD_ABOVE;
              end
            end
            if (bval != 8'd0) begin
              key_nonzero = 1'b1;
            end
            bidx      = bytes_out[4:0];
            bytes_out = bytes_out + 6'd1;
            got_byte  = 1'b1;
          end
        end
        bit_acc  = 8'(acc & ((12'd1 << nbits) - 12'd1));
        bit_fill = nbits;
      end
    end else begin
      // too long: nothing but the length error
      err_flags[ST_MALFORMED] = 1'b1;
    end

    if (char_pos != POS_CEIL) begin
      char_pos = char_pos + 7'd1;
    end

    // end of string: final checks, lowest code wins
    if (last) begin
      if (pos != STR_LEN - 1) begin
        err_flags[ST_MALFORMED] = 1'b1;
      end
      if (residue != 30'd1) begin
        err_flags[ST_CHECKSUM] = 1'b1;
      end
      if (bit_acc[3:0] != 4'd0 || bit_fill >= 4'd5) begin
        err_flags[ST_PADDING] = 1'b1;
      end
      if (!key_nonzero || order_cmp != ORD_BELOW) begin
        err_flags[ST_SCALAR] = 1'b1;
      end
      st = ST_OK;
      for (int code = 6; code >= 1; code--) begin
        if (err_flags[code]) begin
          st = status_t'(code);
        end
      end
      due = '{kind: KIND_STATUS, key_byte: 8'd0, byte_index: 5'd0, status: st};
      key_results_due = {key_results_due, due};
      clear_string();
    end else if (got_byte) begin
      due = '{kind: KIND_BYTE, key_byte: bval, byte_index: bidx, status: ST_OK};
      key_results_due = {key_results_due, due};
    end
  endtask

  function automatic void note_mismatch(input string what, input key_result_t want,
                                        input key_result_t seen);
    if (fail_total < 10) begin
      $display("%0t: mismatch (%s): expected kind=%0d byte=%02h index=%0d status=%0d,",
               $time, what, want.kind, want.key_byte, want.byte_index, want.status);
      $display("    got kind=%0d byte=%02h index=%0d status=%0d",
               seen.kind, seen.key_byte, seen.byte_index, seen.status);
    end
    fail_total++;
  endfunction

  // compare a taken result with the oldest prediction
  task automatic check_result();
    key_result_t seen;
    key_result_t want;
    seen = '{kind: out_mon.kind, key_byte: out_mon.key_byte, byte_index: out_mon.byte_index,
             status: status_t'(out_mon.status)};
    if (key_results_due.size() == 0) begin
      note_mismatch("no result due", '0, seen);
    end else begin
      want = key_results_due.pop_front();
      if (seen.kind !== want.kind || seen.key_byte !== want.key_byte ||
          seen.byte_index !== want.byte_index || seen.status !== want.status) begin
        note_mismatch("wrong field", want, seen);
      end
    end
  endtask

  // results first: a result taken now never belongs to a request taken now
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_string();
      key_results_due.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        check_result();
      end
      if (in_mon.valid && in_mon.ready) begin
        decode_char(in_mon.char_in, in_mon.end_of_string);
      end
    end
    outstanding <= key_results_due.size();
  end

endmodule

@@ verif/bech32_secret_key_decoder_test.sv @@
`timescale 1ns / 100ps
// Top of the nsec decoder testbench: clock, reset, string stimulus and result drain.
// Depends on b32k_pkg, b32k_tb_pkg, the channel interfaces and nsec_decode_checker.

module bech32_secret_key_decoder_test;
  import b32k_pkg::*;
  import b32k_tb_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int CHAR_BUDGET = 1150;
  localparam int LONG_HOLD   = 300;

  typedef enum int {
    FORM_GOOD, FORM_CHECKSUM, FORM_UPPER, FORM_ONE, FORM_BADCHAR, FORM_SHORT, FORM_LONG,
    FORM_SPACE, FORM_PREFIX, FORM_PADDING, FORM_ZERO_KEY, FORM_ORDER, FORM_NOISE, NUM_FORMS
  } text_form_t;

  logic        clk;
  logic        rst_n;
  int unsigned failures;
  int unsigned outstanding;
  int unsigned results_taken = 0;
  int unsigned chars_sent = 0;
  bit          steady = 1'b0;
  logic [7:0]  key_buf [32];
  logic [7:0]  text_q [$];

  b32k_in_if  in_chan ();
  b32k_out_if out_chan ();

  bech32_secret_key_decoder i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  nsec_decode_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_chan),
    .out_mon     (out_chan),
    .failures    (failures),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] blank_char(input int k);
    case (k)
      0:       return 8'h20;
      1:       return 8'h09;
      2:       return 8'h0A;
      default: return 8'h0D;
    endcase
  endfunction

  task automatic send_char(input logic [7:0] ch, input logic last);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.char_in       <= ch;
    in_chan.end_of_string <= last;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    chars_sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) begin
      send_char(text_q[i], i == text_q.size() - 1);
    end
  endtask

  task automatic send_literal(input string s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) begin
      text_q = {text_q, s[i]};
    end
    send_text();
  endtask

  // pause the sender until every predicted result has been taken
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // encode a key as an nsec string, then damage it as the form asks
  task automatic build_text(input text_form_t form);
    logic [259:0] bits;
    logic [29:0]  crc;
    logic [4:0]   w;
    logic [7:0]   ch;
    int           pos;
    int           pick;
    int           len;
    for (int b = 0; b < KEY_LEN; b++) begin
      key_buf[b] = 8'($urandom);
    end
    if (form == FORM_ZERO_KEY) begin
      for (int b = 0; b < KEY_LEN; b++) key_buf[b] = 8'h00;
    end else if (form == FORM_ORDER) begin
      pick = $urandom_range(0, 4);
      for (int b = 0; b < KEY_LEN; b++) begin
        key_buf[b] = (pick == 3) ? 8'hFF : (pick == 4) ? 8'h00 : GROUP_ORDER[b];
      end
      case (pick)
        0:       key_buf[31] = 8'h40;
        2:       key_buf[31] = 8'h42;
        4:       key_buf[31] = 8'h01;
        default: ;
      endcase
    end

    // 256 key bits plus 4 pad bits make 52 words
    for (int b = 0; b < KEY_LEN; b++) begin
      bits[259 - 8 * b -: 8] = key_buf[b];
    end
    bits[3:0] = (form == FORM_PADDING) ? 4'($urandom_range(1, 15)) : 4'h0;

    text_q.delete();
    for (int i = 0; i < HEAD_LEN; i++) begin
      text_q = {text_q, prefix_byte(i)};
    end
    crc = hrp_residue();
    for (int i = 0; i < 52; i++) begin
      w      = bits[259 - 5 * i -: 5];
      crc    = bch_shift(crc, w);
      text_q = {text_q, charset_char(w)};
    end
    for (int i = 0; i < 6; i++) begin
      crc = bch_shift(crc, 5'd0);
    end
    crc = crc ^ 30'd1;
    for (int i = 0; i < 6; i++) begin
      text_q = {text_q, charset_char(crc[5 * (5 - i) +: 5])};
    end

    pos = $urandom_range(HEAD_LEN, STR_LEN - 1);
    case (form)
      FORM_CHECKSUM: begin
        void'(charset_word(text_q[pos], w));
        text_q[pos] = charset_char(w ^ 5'($urandom_range(1, 31)));
      end
      FORM_UPPER: begin
        text_q[$urandom_range(0, STR_LEN - 1)] = 8'($urandom_range(65, 90));
      end
      FORM_ONE: begin
        text_q[pos] = "1";
      end
      FORM_BADCHAR: begin
        do ch = 8'($urandom); while (charset_word(ch, w) || ch == "1");
        text_q[pos] = ch;
      end
      FORM_SHORT: begin
        len = $urandom_range(1, STR_LEN - 1);
        while (text_q.size() > len) void'(text_q.pop_back());
      end
      FORM_LONG: begin
        repeat ($urandom_range(1, 6)) text_q = {text_q, charset_char(5'($urandom))};
      end
      FORM_SPACE: begin
        ch = blank_char($urandom_range(0, 3));
        case ($urandom_range(0, 3))
          0:       text_q.push_front(ch);
          1:       text_q = {text_q, ch};
          2:       text_q[0] = ch;
          default: text_q[STR_LEN - 1] = ch;
        endcase
      end
      FORM_PREFIX: begin
        pos = $urandom_range(0, HEAD_LEN - 1);
        do ch = 8'($urandom); while (ch == text_q[pos]);
        text_q[pos] = ch;
      end
      FORM_NOISE: begin
        text_q.delete();
        repeat ($urandom_range(1, 24)) text_q = {text_q, 8'($urandom)};
      end
      default: ;
    endcase
  endtask

  // main stimulus
  initial begin : stimulus
    text_form_t form;
    int         strings_sent;
    rst_n                 <= 1'b0;
    in_chan.valid         <= 1'b0;
    in_chan.char_in       <= 8'h00;
    in_chan.end_of_string <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: short strings ending early, odd first characters
    send_literal(" ");
    send_literal("Z");
    text_q = '{8'hFF};
    send_text();
    text_q = '{8'h00};
    send_text();
    send_literal("nsec1");
    send_literal("nsec1q1");
    send_literal("nsec1qb");
    send_literal("xsec");
    drain_results();

    // random strings: every form once, then mostly well-formed keys
    strings_sent = 0;
    while (chars_sent < CHAR_BUDGET) begin
      if (strings_sent < NUM_FORMS) begin
        form = text_form_t'(strings_sent);
      end else if ($urandom_range(0, 1) == 0) begin
        form = FORM_GOOD;
      end else begin
        form = text_form_t'($urandom_range(0, NUM_FORMS - 1));
      end
      build_text(form);
      steady = ($urandom_range(0, 3) == 0);
      send_text();
      strings_sent++;
      if (strings_sent % 5 == 0) begin
        drain_results();
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // result side: random stalls, with a long hold now and then
  initial begin : result_drain
    int stall;
    int run_len;
    int hold_mark;
    hold_mark = 100;
    out_chan.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (results_taken >= hold_mark) begin
        out_chan.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_mark = hold_mark + 300;
      end
      stall = pick_gap();
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      run_len = $urandom_range(1, 24);
      repeat (run_len) begin
        @(posedge clk);
        if (out_chan.valid && out_chan.ready) results_taken++;
      end
    end
  end

  // end the run when nothing moves for too long
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ filelist.f @@
design/b32k_pkg.sv
design/b32k_in_if.sv
design/b32k_out_if.sv
design/b32k_char_map.sv
design/b32k_core.sv
design/bech32_secret_key_decoder.sv
verif/b32k_tb_pkg.sv
verif/nsec_decode_checker.sv
verif/bech32_secret_key_decoder_test.sv
